[design/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the circular deque core
// Sizes, operation codes, sequencer states, inter-module structs and the
// ring index wrap helper.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Ring depth and derived widths
    localparam int CAPACITY   = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int OP_W       = 3;
    localparam int OCC_W      = 5;
    // Remainder is only taken of non-negative positions, so the sign bit drops
    localparam int DIVIDEND_W = DATA_W - 1;
    localparam int STEP_W     = $clog2(DIVIDEND_W);

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_READ       = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_MEM,
        ST_EMIT
    } state_t;

    // Remainder unit request / response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [CNT_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } div_rsp_t;

    // Ring memory access
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } ring_req_t;

    // (index + offset) mod CAPACITY, where the sum stays below 2*CAPACITY
    function automatic logic [IDX_W-1:0] ring_wrap(input logic [IDX_W:0] sum);
        logic [IDX_W:0] cap;
        cap = (IDX_W+1)'(CAPACITY);
        if (sum >= cap) begin
            ring_wrap = IDX_W'(sum - cap);
        end else begin
            ring_wrap = sum[IDX_W-1:0];
        end
    endfunction

endpackage

[design/circular_deque_with_wrapped_read_core.sv]
// ----------------------------------------------------------------------------
// circular_deque_with_wrapped_read_core: ring deque with modulo read
// Push front/back, pop front, read at (front + position mod count), clear.
// One result transfer for every input transfer.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | s_op, s_data_word, s_position
//  m_      | out       | m_valid / m_ready  | m_read_word, m_found, m_overflow,
//          |           |                    | m_occupancy
//
//  Push, pop, clear, failed reads and unknown ops pass decode (exec) and emit;
//  a valid read passes decode, the bit-serial remainder unit (31 steps, one
//  position bit per cycle), the ring memory read (mem) and emit, then idle.
//  One item is in work at a time; s_ready is high only while the sequencer
//  is idle. A stalled result sits in the output register while the next
//  item is taken; that item then waits in emit, with s_ready low, until the
//  stalled result leaves. Reset clears pointers and count; ring words stay unknown.
// ----------------------------------------------------------------------------
module circular_deque_with_wrapped_read_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cdq_pkg::OP_W-1:0]          s_op,
    input  logic signed [cdq_pkg::DATA_W-1:0] s_data_word,
    input  logic signed [cdq_pkg::DATA_W-1:0] s_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cdq_pkg::DATA_W-1:0] m_read_word,
    output logic                              m_found,
    output logic                              m_overflow,
    output logic [cdq_pkg::OCC_W-1:0]         m_occupancy
);
    import cdq_pkg::*;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg, m_valid_next;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [DATA_W-1:0] pos_reg, pos_next;
    logic [DATA_W-1:0] res_word_reg, res_word_next;
    logic              res_found_reg, res_found_next;
    logic              res_ovf_reg, res_ovf_next;
    logic [DATA_W-1:0] m_word_reg, m_word_next;
    logic              m_found_reg, m_found_next;
    logic              m_ovf_reg, m_ovf_next;
    logic [OCC_W-1:0]  m_occ_reg, m_occ_next;

    div_req_t          div_req;
    div_rsp_t          div_rsp;
    ring_req_t         ring_req;
    logic [DATA_W-1:0] ring_rd_data;

    logic              read_ok;
    logic              full;
    logic              emit_load;

    assign full    = (count_reg >= CNT_W'(CAPACITY));
    assign read_ok = (op_reg == OP_READ) && (count_reg != '0) && !pos_reg[DATA_W-1];

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = read_ok ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        emit_load        = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
        div_req.start    = (state_reg == ST_EXEC) && read_ok;
        div_req.dividend = pos_reg[DIVIDEND_W-1:0];
        div_req.divisor  = count_reg;
    end

    // Deque state, ring accesses and result capture
    always_comb begin
        front_next       = front_reg;
        count_next       = count_reg;
        op_next          = op_reg;
        data_next        = data_reg;
        pos_next         = pos_reg;
        res_word_next    = res_word_reg;
        res_found_next   = res_found_reg;
        res_ovf_next     = res_ovf_reg;
        ring_req.wr_en   = 1'b0;
        ring_req.wr_addr = front_reg;
        ring_req.wr_data = data_reg;

        // ring read once the remainder is ready
        ring_req.rd_en   = (state_reg == ST_DIV) && div_rsp.done;
        ring_req.rd_addr = ring_wrap({1'b0, front_reg} + (IDX_W+1)'(div_rsp.remainder));

        // latch item on transfer
        if (s_valid && s_ready) begin
            op_next   = s_op;
            data_next = s_data_word;
            pos_next  = s_position;
        end

        if (state_reg == ST_EXEC) begin
            res_word_next  = '0;
            res_found_next = 1'b0;
            res_ovf_next   = 1'b0;
            case (op_reg)
                OP_PUSH_FRONT: begin
                    if (full) begin
                        res_ovf_next = 1'b1;
                    end else begin
                        front_next       = (front_reg == '0) ? IDX_W'(CAPACITY - 1)
                                                             : front_reg - 1'b1;
                        ring_req.wr_en   = 1'b1;
                        ring_req.wr_addr = front_next;
                        count_next       = count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK: begin
                    if (full) begin
                        res_ovf_next = 1'b1;
                    end else begin
                        ring_req.wr_en   = 1'b1;
                        ring_req.wr_addr = ring_wrap({1'b0, front_reg}
                                                     + (IDX_W+1)'(count_reg));
                        count_next       = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (count_reg != '0) begin
                        front_next = ring_wrap({1'b0, front_reg} + 1'b1);
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_READ: begin
                    if (!read_ok) begin
                        res_word_next = '1;
                    end
                end
                OP_CLEAR: begin
                    front_next = '0;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end

        // ring word arrives in the cycle after the read
        if (state_reg == ST_MEM) begin
            res_word_next  = ring_rd_data;
            res_found_next = 1'b1;
        end
    end

    // Output register
    always_comb begin
        m_word_next  = m_word_reg;
        m_found_next = m_found_reg;
        m_ovf_next   = m_ovf_reg;
        m_occ_next   = m_occ_reg;
        m_valid_next = m_valid_reg;
        if (emit_load) begin
            m_valid_next = 1'b1;
            m_word_next  = res_word_reg;
            m_found_next = res_found_reg;
            m_ovf_next   = res_ovf_reg;
            m_occ_next   = OCC_W'(count_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        data_reg      <= data_next;
        pos_reg       <= pos_next;
        res_word_reg  <= res_word_next;
        res_found_reg <= res_found_next;
        res_ovf_reg   <= res_ovf_next;
        m_word_reg    <= m_word_next;
        m_found_reg   <= m_found_next;
        m_ovf_reg     <= m_ovf_next;
        m_occ_reg     <= m_occ_next;
    end

    cdq_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    cdq_ring u_ring (
        .aclk    (aclk),
        .req     (ring_req),
        .rd_data (ring_rd_data)
    );

    assign m_valid     = m_valid_reg;
    assign m_read_word = m_word_reg;
    assign m_found     = m_found_reg;
    assign m_overflow  = m_ovf_reg;
    assign m_occupancy = m_occ_reg;

endmodule

[design/cdq_divider.sv]
// ----------------------------------------------------------------------------
// cdq_divider: iterative remainder unit
// Restoring shift-subtract, one dividend bit per cycle; produces
// dividend mod divisor for a nonzero divisor.
// ----------------------------------------------------------------------------
module cdq_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  cdq_pkg::div_req_t  req,
    output cdq_pkg::div_rsp_t  rsp
);
    import cdq_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]      divisor_reg, divisor_next;
    logic [CNT_W:0]        trial;

    // One restoring step per cycle
    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        trial        = {rem_reg, shift_reg[DIVIDEND_W-1]};
        if (req.start) begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = '0;
            shift_next   = req.dividend;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            shift_next = {shift_reg[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg}) begin
                rem_next = CNT_W'(trial - {1'b0, divisor_reg});
            end else begin
                rem_next = trial[CNT_W-1:0];
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

[design/cdq_ring.sv]
// ----------------------------------------------------------------------------
// cdq_ring: ring word storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cdq_ring (
    input  logic                       aclk,
    input  cdq_pkg::ring_req_t         req,
    output logic [cdq_pkg::DATA_W-1:0] rd_data
);
    import cdq_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/cdq_checker.sv]
// ----------------------------------------------------------------------------
// cdq_checker: port-level checks for the circular deque core
// Input pacing, result consistency and output stall behavior, bound to the
// top level.
// ----------------------------------------------------------------------------
module cdq_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [cdq_pkg::DATA_W-1:0] m_read_word,
    input logic                              m_found,
    input logic                              m_overflow,
    input logic [cdq_pkg::OCC_W-1:0]         m_occupancy
);
    import cdq_pkg::*;

    // One item in work: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken back to back");

    // Stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_word) && $stable(m_found)
                                && $stable(m_overflow) && $stable(m_occupancy))
        else $error("result changed while stalled");

    // A hit never comes with a dropped push
    a_found_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_overflow)
        else $error("found and overflow both set");

    // A miss returns zero (non-read) or all ones (failed read)
    a_miss_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> (m_read_word == '0) || (m_read_word == '1))
        else $error("miss with unexpected word");

    // Overflow only when the ring is full
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_occupancy == OCC_W'(CAPACITY))
        else $error("overflow below capacity");

endmodule

bind circular_deque_with_wrapped_read_core cdq_checker u_cdq_checker (.*);
